// ----- design/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// skf_pkg: shared types and constants for the scalar Kalman filter
// Field widths, register indexes, step kinds and saturation limits.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int DATA_W        = 32;
    localparam int VAR_W         = 31;
    localparam int CFG_IDX_W     = 3;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [VAR_W-1:0]         t_var;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;

    // configuration register indexes
    localparam t_cfg_idx REG_TRANSITION  = 3'd0;
    localparam t_cfg_idx REG_CONTROL     = 3'd1;
    localparam t_cfg_idx REG_OBSERVATION = 3'd2;
    localparam t_cfg_idx REG_PROC_NOISE  = 3'd3;
    localparam t_cfg_idx REG_MEAS_NOISE  = 3'd4;

    // item kinds
    localparam logic KIND_PREDICT = 1'b0;
    localparam logic KIND_CORRECT = 1'b1;

    localparam t_data DATA_MAX = 32'sh7FFF_FFFF;
    localparam t_data DATA_MIN = 32'sh8000_0000;
    localparam t_var  VAR_MAX  = 31'h7FFF_FFFF;

endpackage

// ----- design/skf_in_if.sv -----
// ----------------------------------------------------------------------------
// skf_in_if: input item channel
// One beat carries a step kind and a control value or measurement.
// ----------------------------------------------------------------------------
interface skf_in_if;
    logic                valid;
    logic                ready;
    logic                kind;
    skf_pkg::t_data      sample_value;

    modport source (output valid, kind, sample_value, input ready);
    modport sink   (input valid, kind, sample_value, output ready);
endinterface

// ----- design/skf_out_if.sv -----
// ----------------------------------------------------------------------------
// skf_out_if: result channel
// One beat carries the new estimate, the new variance and a clip flag.
// ----------------------------------------------------------------------------
interface skf_out_if;
    logic                valid;
    logic                ready;
    skf_pkg::t_data      estimate;
    skf_pkg::t_var       variance;
    logic                saturated;

    modport source (output valid, estimate, variance, saturated, input ready);
    modport sink   (input valid, estimate, variance, saturated, output ready);
endinterface

// ----- design/skf_cfg_if.sv -----
// ----------------------------------------------------------------------------
// skf_cfg_if: configuration write channel
// One beat writes data to the register selected by index.
// ----------------------------------------------------------------------------
interface skf_cfg_if;
    logic                valid;
    logic                ready;
    skf_pkg::t_cfg_idx   index;
    skf_pkg::t_data      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/skf_smul.sv -----
// ----------------------------------------------------------------------------
// skf_smul: bit-serial signed fixed-point multiplier
// One multiplier bit per cycle; result is the product rounded half up and
// shifted down by FRAC_BITS.
// ----------------------------------------------------------------------------
module skf_smul #(
    parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  skf_pkg::t_data                         i_mcand,
    input  skf_pkg::t_data                         i_mplier,
    output logic                                   o_done,
    output logic signed [2*skf_pkg::DATA_W-FRAC_BITS-1:0] o_result
);

    localparam int DW     = skf_pkg::DATA_W;
    localparam int PROD_W = 2 * DW;
    localparam int CNT_W  = $clog2(DW);
    localparam logic signed [PROD_W-1:0] HALF =
        {{(PROD_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    logic                     r_busy;
    logic                     r_done;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [PROD_W-1:0] r_mcand;
    logic [DW-1:0]            r_mplier;
    logic signed [PROD_W-1:0] r_acc;

    logic signed [PROD_W-1:0] w_term;
    logic                     w_last;
    logic signed [PROD_W-1:0] n_acc;

    // the top multiplier bit carries negative weight
    always_comb begin
        w_term = r_mplier[0] ? r_mcand : '0;
        w_last = (r_cnt == CNT_W'(DW - 1));
        n_acc  = w_last ? (r_acc - w_term) : (r_acc + w_term);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= PROD_W'(i_mcand);
            r_mplier <= i_mplier;
            r_acc    <= HALF;
        end else if (r_busy) begin
            r_acc    <= n_acc;
            r_mcand  <= r_mcand <<< 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_done   = r_done;
    assign o_result = $signed(r_acc[PROD_W-1:FRAC_BITS]);

endmodule

// ----- design/skf_sdiv.sv -----
// ----------------------------------------------------------------------------
// skf_sdiv: bit-serial restoring divider for the Kalman gain
// Computes round(num * 2^FRAC_BITS / den), halves away from zero, saturated
// to 32 bits; a non-positive denominator gives zero.
// ----------------------------------------------------------------------------
module skf_sdiv #(
    parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  skf_pkg::t_data i_num,
    input  skf_pkg::t_data i_den,
    output logic           o_done,
    output skf_pkg::t_data o_quo,
    output logic           o_clip
);

    localparam int DW    = skf_pkg::DATA_W;
    localparam int DVD_W = DW + FRAC_BITS + 1;
    localparam int CNT_W = $clog2(DVD_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_neg;
    logic [DVD_W-1:0]  r_dvd;
    logic [DW-2:0]     r_den;
    logic [DW-2:0]     r_rem;

    logic [DW-1:0]     w_mag;
    logic [DVD_W-1:0]  w_dvd;
    logic              w_den_bad;
    logic              w_last;
    logic [DW-1:0]     w_rem_sh;
    logic [DW-1:0]     w_diff;
    logic              w_ge;
    logic [DW-1:0]     w_q_lo;
    logic              w_hi_any;

    always_comb begin
        w_mag     = i_num[DW-1] ? (~i_num + 1'b1) : i_num;
        w_dvd     = {1'b0, w_mag, {FRAC_BITS{1'b0}}} + DVD_W'(i_den[DW-1:1]);
        w_den_bad = i_den[DW-1] || (i_den == '0);
        w_last    = (r_cnt == CNT_W'(DVD_W - 1));
        w_rem_sh  = {r_rem, r_dvd[DVD_W-1]};
        w_diff    = w_rem_sh - {1'b0, r_den};
        w_ge      = (w_rem_sh >= {1'b0, r_den});
        w_q_lo    = r_dvd[DW-1:0];
        w_hi_any  = |r_dvd[DVD_W-1:DW];
        if (r_neg) begin
            o_clip = w_hi_any || (r_dvd[DW-1] && (|r_dvd[DW-2:0]));
        end else begin
            o_clip = w_hi_any || r_dvd[DW-1];
        end
        if (o_clip) begin
            o_quo = r_neg ? skf_pkg::DATA_MIN : skf_pkg::DATA_MAX;
        end else begin
            o_quo = r_neg ? $signed(-w_q_lo) : $signed(w_q_lo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                if (w_den_bad) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift one quotient bit in per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= w_den_bad ? 1'b0 : i_num[DW-1];
            r_dvd <= w_den_bad ? '0 : w_dvd;
            r_den <= i_den[DW-2:0];
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-2:0] : w_rem_sh[DW-2:0];
            r_dvd <= {r_dvd[DVD_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;

endmodule

// ----- design/scalar_kalman_filter_top.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top: one-dimensional Kalman filter, signed fixed point
//
//   channel   dir   beat contents                        handshake
//   i_cfg     in    index, data (register write)          valid/ready, ready tied high
//   i_in      in    kind, sample_value                   valid/ready
//   o_out     out   estimate, variance, saturated        valid/ready
//
// Every product of a step goes through one shared bit-serial multiplier;
// the gain of a correct item goes through a bit-serial divider, one
// quotient bit per cycle.
// One item is worked on at a time; the next is taken while a result waits.
// Reset restores the register defaults and sets estimate and variance to 1.0.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_top #(
    parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    skf_cfg_if.sink   i_cfg,
    skf_in_if.sink    i_in,
    skf_out_if.source o_out
);

    localparam int DW    = skf_pkg::DATA_W;
    localparam int VW    = skf_pkg::VAR_W;
    localparam int MUL_W = 2 * DW - FRAC_BITS;
    localparam int SUM_W = MUL_W + 1;

    localparam int R_RST_I = (4 << FRAC_BITS) / 100;
    localparam skf_pkg::t_data GAIN_HALF = skf_pkg::t_data'(1) <<< (FRAC_BITS - 1);
    localparam skf_pkg::t_data GAIN_ONE  = skf_pkg::t_data'(1) <<< FRAC_BITS;
    localparam skf_pkg::t_var  Q_RST     = skf_pkg::t_var'(1) << (FRAC_BITS - 2);
    localparam skf_pkg::t_var  R_RST     = VW'(R_RST_I);
    localparam skf_pkg::t_var  VAR_ONE   = skf_pkg::t_var'(1) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(1) <<< FRAC_BITS;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // predict steps
    localparam logic [2:0] PS_AA  = 3'd0;
    localparam logic [2:0] PS_AX  = 3'd1;
    localparam logic [2:0] PS_BU  = 3'd2;
    localparam logic [2:0] PS_VAR = 3'd3;
    // correct steps
    localparam logic [2:0] CS_N    = 3'd0;
    localparam logic [2:0] CS_HH   = 3'd1;
    localparam logic [2:0] CS_D    = 3'd2;
    localparam logic [2:0] CS_E    = 3'd3;
    localparam logic [2:0] CS_KEEP = 3'd4;
    localparam logic [2:0] CS_X    = 3'd5;
    localparam logic [2:0] CS_VAR  = 3'd6;

    logic [1:0]              r_state;
    logic [2:0]              r_step;
    logic                    r_kind;
    logic                    r_flag;
    logic                    r_mstart;
    logic                    r_dstart;
    logic                    r_ov;
    skf_pkg::t_data          r_a;
    skf_pkg::t_data          r_b;
    skf_pkg::t_data          r_h;
    skf_pkg::t_var           r_q;
    skf_pkg::t_var           r_r;
    skf_pkg::t_data          r_x;
    skf_pkg::t_var           r_p;

    skf_pkg::t_data          r_smp;
    skf_pkg::t_data          r_ta;
    skf_pkg::t_data          r_tb;
    skf_pkg::t_data          r_tc;
    logic signed [MUL_W-1:0] r_w;
    skf_pkg::t_data          r_oest;
    skf_pkg::t_var           r_ovar;
    logic                    r_osat;

    skf_pkg::t_data          w_op_a;
    skf_pkg::t_data          w_op_b;
    skf_pkg::t_data          w_p_op;
    logic signed [SUM_W-1:0] w_addend;
    logic                    w_sub;
    logic                    w_use_satv;
    logic                    w_store_wide;
    logic signed [SUM_W-1:0] w_sum;
    logic [SUM_W-DW:0]       w_hi;
    logic                    w_fit32;
    skf_pkg::t_data          w_s32;
    skf_pkg::t_var           w_sv;
    logic                    w_clip;
    logic                    w_last_step;
    logic                    w_mul_done;
    logic signed [MUL_W-1:0] w_m;
    logic                    w_div_done;
    skf_pkg::t_data          w_quo;
    logic                    w_div_clip;

    skf_smul #(.FRAC_BITS(FRAC_BITS)) u_smul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mstart),
        .i_mcand  (w_op_a),
        .i_mplier (w_op_b),
        .o_done   (w_mul_done),
        .o_result (w_m)
    );

    skf_sdiv #(.FRAC_BITS(FRAC_BITS)) u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_ta),
        .i_den   (r_tc),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_clip  (w_div_clip)
    );

    // operand and post-product selection per step
    always_comb begin
        w_p_op       = $signed({1'b0, r_p});
        w_op_a       = r_a;
        w_op_b       = r_a;
        w_addend     = '0;
        w_sub        = 1'b0;
        w_use_satv   = 1'b0;
        w_store_wide = 1'b0;
        if (r_kind == skf_pkg::KIND_PREDICT) begin
            case (r_step)
                PS_AA: begin
                    w_use_satv = 1'b1;
                end
                PS_AX: begin
                    w_op_b       = r_x;
                    w_store_wide = 1'b1;
                end
                PS_BU: begin
                    w_op_a   = r_b;
                    w_op_b   = r_smp;
                    w_addend = SUM_W'(r_w);
                end
                PS_VAR: begin
                    w_op_a     = r_ta;
                    w_op_b     = w_p_op;
                    w_addend   = $signed(SUM_W'(r_q));
                    w_use_satv = 1'b1;
                end
                default: begin
                    w_op_a = r_a;
                end
            endcase
        end else begin
            case (r_step)
                CS_N: begin
                    w_op_a = w_p_op;
                    w_op_b = r_h;
                end
                CS_HH: begin
                    w_op_a     = r_h;
                    w_op_b     = r_h;
                    w_use_satv = 1'b1;
                end
                CS_D: begin
                    w_op_a   = r_tb;
                    w_op_b   = w_p_op;
                    w_addend = $signed(SUM_W'(r_r));
                end
                CS_E: begin
                    w_op_a   = r_h;
                    w_op_b   = r_x;
                    w_addend = SUM_W'(r_smp);
                    w_sub    = 1'b1;
                end
                CS_KEEP: begin
                    w_op_a   = r_tb;
                    w_op_b   = r_h;
                    w_addend = ONE_S;
                    w_sub    = 1'b1;
                end
                CS_X: begin
                    w_op_a   = r_tb;
                    w_op_b   = r_tc;
                    w_addend = SUM_W'(r_x);
                end
                CS_VAR: begin
                    w_op_a     = r_ta;
                    w_op_b     = w_p_op;
                    w_use_satv = 1'b1;
                end
                default: begin
                    w_op_a = r_a;
                end
            endcase
        end

        w_sum   = w_sub ? (w_addend - SUM_W'(w_m)) : (w_addend + SUM_W'(w_m));
        w_hi    = w_sum[SUM_W-1:DW-1];
        w_fit32 = (&w_hi) || (~|w_hi);
        if (w_fit32) begin
            w_s32 = w_sum[DW-1:0];
        end else begin
            w_s32 = w_sum[SUM_W-1] ? skf_pkg::DATA_MIN : skf_pkg::DATA_MAX;
        end
        // sign bit sits in w_hi, so any bit set there means a clip
        if (w_sum[SUM_W-1]) begin
            w_sv = '0;
        end else if (|w_hi) begin
            w_sv = skf_pkg::VAR_MAX;
        end else begin
            w_sv = w_sum[VW-1:0];
        end

        if (w_store_wide) begin
            w_clip = 1'b0;
        end else if (w_use_satv) begin
            w_clip = |w_hi;
        end else begin
            w_clip = !w_fit32;
        end

        w_last_step = (r_kind == skf_pkg::KIND_CORRECT) ? (r_step == CS_VAR)
                                                        : (r_step == PS_VAR);
    end

    // control, configuration and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_kind   <= skf_pkg::KIND_PREDICT;
            r_flag   <= 1'b0;
            r_mstart <= 1'b0;
            r_dstart <= 1'b0;
            r_ov     <= 1'b0;
            r_a      <= GAIN_HALF;
            r_b      <= GAIN_HALF;
            r_h      <= GAIN_ONE;
            r_q      <= Q_RST;
            r_r      <= R_RST;
            r_x      <= GAIN_ONE;
            r_p      <= VAR_ONE;
        end else begin
            r_mstart <= 1'b0;
            r_dstart <= 1'b0;

            if (i_cfg.valid) begin
                case (i_cfg.index)
                    skf_pkg::REG_TRANSITION:  r_a <= i_cfg.data;
                    skf_pkg::REG_CONTROL:     r_b <= i_cfg.data;
                    skf_pkg::REG_OBSERVATION: r_h <= i_cfg.data;
                    skf_pkg::REG_PROC_NOISE:  r_q <= i_cfg.data[VW-1:0];
                    skf_pkg::REG_MEAS_NOISE:  r_r <= i_cfg.data[VW-1:0];
                    default:                  r_a <= r_a;
                endcase
            end

            if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_kind   <= i_in.kind;
                        r_step   <= '0;
                        r_flag   <= 1'b0;
                        r_mstart <= 1'b1;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        r_flag <= r_flag | w_clip;
                        if (r_kind == skf_pkg::KIND_PREDICT) begin
                            if (r_step == PS_BU) begin
                                r_x <= w_s32;
                            end
                            if (r_step == PS_VAR) begin
                                r_p <= w_sv;
                            end
                        end else begin
                            if (r_step == CS_X) begin
                                r_x <= w_s32;
                            end
                            if (r_step == CS_VAR) begin
                                r_p <= w_sv;
                            end
                        end
                        if (w_last_step) begin
                            r_state <= S_DONE;
                        end else begin
                            r_step <= r_step + 1'b1;
                            if (r_kind == skf_pkg::KIND_CORRECT && r_step == CS_D) begin
                                r_dstart <= 1'b1;
                                r_state  <= S_DIV;
                            end else begin
                                r_mstart <= 1'b1;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_flag   <= r_flag | w_div_clip;
                        r_mstart <= 1'b1;
                        r_state  <= S_MUL;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_ov || o_out.ready) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath temporaries and output beat
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_smp <= i_in.sample_value;
        end
        if (r_state == S_MUL && w_mul_done) begin
            if (r_kind == skf_pkg::KIND_PREDICT) begin
                case (r_step)
                    PS_AA:   r_ta <= $signed({1'b0, w_sv});
                    PS_AX:   r_w  <= w_m;
                    default: r_ta <= r_ta;
                endcase
            end else begin
                case (r_step)
                    CS_N:    r_ta <= w_s32;
                    CS_HH:   r_tb <= $signed({1'b0, w_sv});
                    CS_D:    r_tc <= w_s32;
                    CS_E:    r_tc <= w_s32;
                    CS_KEEP: r_ta <= w_s32;
                    default: r_ta <= r_ta;
                endcase
            end
        end
        if (r_state == S_DIV && w_div_done) begin
            r_tb <= w_quo;
        end
        if (r_state == S_DONE && (!r_ov || o_out.ready)) begin
            r_oest <= r_x;
            r_ovar <= r_p;
            r_osat <= r_flag;
        end
    end

    assign i_cfg.ready     = 1'b1;
    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ov;
    assign o_out.estimate  = r_oest;
    assign o_out.variance  = r_ovar;
    assign o_out.saturated = r_osat;

endmodule

// ----- tb/scalar_kalman_filter_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top_tb: self-checking bench for the scalar Kalman filter
// Sends predict and correct beats under many register settings. These include
// the extremes, a zero gain denominator and clipped variances. The bench keeps
// its own fixed-point copy of the filter state and compares every result beat
// with it, field by field. Both channel ends idle at random, and once the
// result side holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_top_tb;

    localparam int     FRAC           = skf_pkg::FRAC_BITS_DEF;
    localparam int     CLK_HALF       = 5;
    localparam int     RESET_CYCLES   = 9;
    localparam int     MAX_WAIT       = 13;
    localparam int     HOLD_CYCLES    = 800;
    localparam int     DRAIN_CYCLES   = 400;
    localparam int     RAND_PHASES    = 12;
    localparam int     NUM_DIR_ROWS   = 22;
    localparam int     NUM_DIR_SETS   = 6;
    localparam int     GAIN_SPAN      = 81920;     // +/- 1.25
    localparam int     NOISE_SPAN     = 65536;     // up to 1.0
    localparam int     SAMPLE_SPAN    = 1048576;   // +/- 16.0
    localparam longint TIMEOUT_CYCLES = 2_500_000;
    localparam longint S32_HI         = 64'sd2147483647;
    localparam longint S32_LO         = -64'sd2147483648;
    localparam longint ONE            = 64'sd1 <<< FRAC;

    typedef struct packed {
        skf_pkg::t_data estimate;
        skf_pkg::t_var  variance;
        logic           saturated;
    } t_update;

    typedef struct packed {
        skf_pkg::t_data a;
        skf_pkg::t_data b;
        skf_pkg::t_data h;
        skf_pkg::t_data q;
        skf_pkg::t_data r;
    } t_reg_set;

    typedef struct packed {
        logic [2:0]     set_id;
        logic           kind;
        skf_pkg::t_data sample;
        logic           typed;
        t_update        upd;
    } t_dir_row;

    localparam t_update NO_UPD = '0;

    logic i_clk = 1'b0;
    logic i_rst_n;

    skf_cfg_if cfg_bus ();
    skf_in_if  step_bus ();
    skf_out_if upd_bus ();

    scalar_kalman_filter_top #(
        .FRAC_BITS(FRAC)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_bus),
        .i_in   (step_bus),
        .o_out  (upd_bus)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // filter state and registers as the bench sees them
    longint  trans_gain;
    longint  ctrl_gain;
    longint  obs_gain;
    longint  proc_noise;
    longint  meas_noise;
    longint  filt_x;
    longint  filt_p;
    bit      clip_hit;

    t_update expected_updates[$];

    int mismatch_count = 0;
    int predicts_sent  = 0;
    int corrects_sent  = 0;
    int updates_seen   = 0;
    int clipped_seen   = 0;
    int settings_used  = 0;
    bit send_burst     = 1'b0;
    bit recv_burst     = 1'b0;
    bit hold_request   = 1'b0;

    // Q16.16 product, round half up
    function automatic longint qmul(longint a, longint b);
        return (a * b + (ONE >>> 1)) >>> FRAC;
    endfunction

    function automatic longint clip_s32(longint v);
        if (v > S32_HI) begin
            clip_hit = 1'b1;
            return S32_HI;
        end
        if (v < S32_LO) begin
            clip_hit = 1'b1;
            return S32_LO;
        end
        return v;
    endfunction

    function automatic longint clip_var(longint v);
        if (v > S32_HI) begin
            clip_hit = 1'b1;
            return S32_HI;
        end
        if (v < 0) begin
            clip_hit = 1'b1;
            return 0;
        end
        return v;
    endfunction

    // n / d in Q16.16, nearest with halves away from zero; zero when d is not positive
    function automatic longint kalman_gain(longint n, longint d);
        longint mag;
        longint q;
        if (d <= 0)
            return 0;
        mag = (n < 0 ? -n : n) <<< FRAC;
        q   = (mag + d / 2) / d;
        if (q > (64'sd1 <<< 40))
            q = 64'sd1 <<< 40;
        return clip_s32(n < 0 ? -q : q);
    endfunction

    function automatic void model_write(skf_pkg::t_cfg_idx idx, skf_pkg::t_data val);
        case (idx)
            skf_pkg::REG_TRANSITION:  trans_gain = longint'(val);
            skf_pkg::REG_CONTROL:     ctrl_gain  = longint'(val);
            skf_pkg::REG_OBSERVATION: obs_gain   = longint'(val);
            skf_pkg::REG_PROC_NOISE:  proc_noise = longint'(val[skf_pkg::VAR_W-1:0]);
            skf_pkg::REG_MEAS_NOISE:  meas_noise = longint'(val[skf_pkg::VAR_W-1:0]);
            default: ;
        endcase
    endfunction

    // advance the filter by one step and return the result beat it gives
    function automatic t_update filter_step(logic kind, skf_pkg::t_data sample);
        longint  s;
        longint  aa;
        longint  n;
        longint  hh;
        longint  d;
        longint  g;
        longint  e;
        longint  keep;
        t_update upd;
        s        = longint'(sample);
        clip_hit = 1'b0;
        if (kind == skf_pkg::KIND_PREDICT) begin
            aa     = clip_var(qmul(trans_gain, trans_gain));
            filt_x = clip_s32(qmul(trans_gain, filt_x) + qmul(ctrl_gain, s));
            filt_p = clip_var(qmul(aa, filt_p) + proc_noise);
        end else begin
            n      = clip_s32(qmul(filt_p, obs_gain));
            hh     = clip_var(qmul(obs_gain, obs_gain));
            d      = clip_s32(qmul(hh, filt_p) + meas_noise);
            g      = kalman_gain(n, d);
            e      = clip_s32(s - qmul(obs_gain, filt_x));
            keep   = clip_s32(ONE - qmul(g, obs_gain));
            filt_x = clip_s32(filt_x + qmul(g, e));
            filt_p = clip_var(qmul(keep, filt_p));
        end
        upd.estimate  = skf_pkg::t_data'(filt_x);
        upd.variance  = skf_pkg::t_var'(filt_p);
        upd.saturated = clip_hit;
        return upd;
    endfunction

    function automatic skf_pkg::t_data pick_gain();
        case ($urandom_range(0, 9))
            0:       return skf_pkg::DATA_MAX;
            1:       return skf_pkg::DATA_MIN;
            2:       return skf_pkg::t_data'($urandom);
            default: return skf_pkg::t_data'(int'($urandom_range(0, 2 * GAIN_SPAN))
                                             - GAIN_SPAN);
        endcase
    endfunction

    function automatic skf_pkg::t_data pick_noise();
        skf_pkg::t_data v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = skf_pkg::DATA_MAX;
            2:       v = skf_pkg::t_data'($urandom);
            default: v = skf_pkg::t_data'($urandom_range(0, NOISE_SPAN));
        endcase
        // the top bit lies outside the register and must be dropped
        v[skf_pkg::DATA_W-1] = $urandom_range(0, 1);
        return v;
    endfunction

    function automatic skf_pkg::t_data pick_sample();
        case ($urandom_range(0, 9))
            0:       return skf_pkg::DATA_MAX;
            1:       return skf_pkg::DATA_MIN;
            2, 3:    return skf_pkg::t_data'($urandom);
            default: return skf_pkg::t_data'(int'($urandom_range(0, 2 * SAMPLE_SPAN))
                                             - SAMPLE_SPAN);
        endcase
    endfunction

    task automatic wait_idle();
        while (expected_updates.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(skf_pkg::t_cfg_idx idx, skf_pkg::t_data val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        model_write(idx, val);
    endtask

    task automatic program_regs(t_reg_set rs);
        wait_idle();
        write_reg(skf_pkg::REG_TRANSITION, rs.a);
        write_reg(skf_pkg::REG_CONTROL, rs.b);
        write_reg(skf_pkg::REG_OBSERVATION, rs.h);
        write_reg(skf_pkg::REG_PROC_NOISE, rs.q);
        write_reg(skf_pkg::REG_MEAS_NOISE, rs.r);
        // unmapped index: must leave every register alone
        write_reg(skf_pkg::t_cfg_idx'($urandom_range(skf_pkg::REG_MEAS_NOISE + 1,
                                                     {skf_pkg::CFG_IDX_W{1'b1}})),
                  skf_pkg::t_data'($urandom));
        cfg_bus.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_step(logic kind, skf_pkg::t_data sample, logic typed,
                             t_update typed_upd);
        int      gap;
        t_update upd;
        gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0) begin
            step_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        step_bus.valid        <= 1'b1;
        step_bus.kind         <= kind;
        step_bus.sample_value <= sample;
        @(posedge i_clk);
        while (!step_bus.ready)
            @(posedge i_clk);
        upd = filter_step(kind, sample);
        expected_updates.push_back(typed ? typed_upd : upd);
        if (kind == skf_pkg::KIND_PREDICT)
            predicts_sent++;
        else
            corrects_sent++;
    endtask

    initial begin : result_sink
        int      stall;
        t_update want;
        upd_bus.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_request) begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                stall = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (stall != 0) begin
                upd_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            upd_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!upd_bus.valid)
                @(posedge i_clk);
            updates_seen++;
            if (upd_bus.saturated === 1'b1)
                clipped_seen++;
            if (expected_updates.size() == 0) begin
                $error("unexpected result beat: estimate %0d variance %0d saturated %0b",
                       upd_bus.estimate, upd_bus.variance, upd_bus.saturated);
                mismatch_count++;
            end else begin
                want = expected_updates.pop_front();
                if (upd_bus.estimate !== want.estimate) begin
                    $error("estimate: expected %0d, actual %0d",
                           want.estimate, upd_bus.estimate);
                    mismatch_count++;
                end
                if (upd_bus.variance !== want.variance) begin
                    $error("variance: expected %0d, actual %0d",
                           want.variance, upd_bus.variance);
                    mismatch_count++;
                end
                if (upd_bus.saturated !== want.saturated) begin
                    $error("saturated: expected %0b, actual %0b",
                           want.saturated, upd_bus.saturated);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_reg_set    dir_sets [NUM_DIR_SETS];
        t_dir_row    dir_rows [NUM_DIR_ROWS];
        t_reg_set    rs;
        int unsigned cur_set;
        int unsigned n_items;
        int          ph;

        i_rst_n               = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = skf_pkg::REG_TRANSITION;
        cfg_bus.data          = '0;
        step_bus.valid        = 1'b0;
        step_bus.kind         = skf_pkg::KIND_PREDICT;
        step_bus.sample_value = '0;

        trans_gain = ONE >>> 1;
        ctrl_gain  = ONE >>> 1;
        obs_gain   = ONE;
        proc_noise = ONE >>> 2;
        meas_noise = (4 * ONE) / 100;
        filt_x     = ONE;
        filt_p     = ONE;

        dir_sets = '{
            '0,   // reset values, not written
            '{skf_pkg::DATA_MAX, skf_pkg::DATA_MIN, skf_pkg::DATA_MAX,
              32'hFFFF_FFFF, 32'h8000_0000},
            '{skf_pkg::DATA_MIN, skf_pkg::DATA_MAX, skf_pkg::DATA_MIN, 32'sd0, 32'sd0},
            // no observation and no measurement noise: the gain denominator is zero
            '{32'sd65536, 32'sd65536, 32'sd0, 32'sd16384, 32'sd0},
            '{32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0},
            '{32'sd65536, 32'sd65536, 32'sd65536, 32'sd16384, 32'sd2621}
        };

        dir_rows = '{
            // from reset: x = 0.5 * 1.0, P = 0.25 * 1.0 + 0.25
            '{3'd0, skf_pkg::KIND_PREDICT, 32'sd0,            1'b1,
              '{32'sd32768, 31'd32768, 1'b0}},
            '{3'd0, skf_pkg::KIND_CORRECT, 32'sd65536,        1'b0, NO_UPD},
            '{3'd0, skf_pkg::KIND_PREDICT, skf_pkg::DATA_MAX, 1'b0, NO_UPD},
            '{3'd0, skf_pkg::KIND_PREDICT, skf_pkg::DATA_MIN, 1'b0, NO_UPD},
            '{3'd0, skf_pkg::KIND_CORRECT, skf_pkg::DATA_MAX, 1'b0, NO_UPD},
            '{3'd0, skf_pkg::KIND_CORRECT, skf_pkg::DATA_MIN, 1'b0, NO_UPD},
            '{3'd0, skf_pkg::KIND_CORRECT, 32'sd0,            1'b0, NO_UPD},
            '{3'd0, skf_pkg::KIND_PREDICT, -32'sd1,           1'b0, NO_UPD},
            // huge observation gain drives the variance below zero
            '{3'd1, skf_pkg::KIND_PREDICT, 32'sd1,            1'b0, NO_UPD},
            '{3'd1, skf_pkg::KIND_CORRECT, skf_pkg::DATA_MAX, 1'b0, NO_UPD},
            '{3'd1, skf_pkg::KIND_CORRECT, skf_pkg::DATA_MIN, 1'b0, NO_UPD},
            '{3'd1, skf_pkg::KIND_PREDICT, 32'sd0,            1'b0, NO_UPD},
            '{3'd2, skf_pkg::KIND_PREDICT, skf_pkg::DATA_MAX, 1'b0, NO_UPD},
            '{3'd2, skf_pkg::KIND_CORRECT, 32'sd0,            1'b0, NO_UPD},
            '{3'd2, skf_pkg::KIND_CORRECT, skf_pkg::DATA_MAX, 1'b0, NO_UPD},
            '{3'd3, skf_pkg::KIND_CORRECT, 32'sd12345,        1'b0, NO_UPD},
            '{3'd3, skf_pkg::KIND_PREDICT, 32'sd0,            1'b0, NO_UPD},
            '{3'd3, skf_pkg::KIND_CORRECT, skf_pkg::DATA_MIN, 1'b0, NO_UPD},
            // transition and control gains zero: state and variance collapse to zero, gain stays zero
            '{3'd4, skf_pkg::KIND_PREDICT, 32'sd7,            1'b1,
              '{32'sd0, 31'd0, 1'b0}},
            '{3'd4, skf_pkg::KIND_CORRECT, skf_pkg::DATA_MAX, 1'b1,
              '{32'sd0, 31'd0, 1'b0}},
            '{3'd5, skf_pkg::KIND_PREDICT, 32'sd65536,        1'b0, NO_UPD},
            '{3'd5, skf_pkg::KIND_CORRECT, 32'sd0,            1'b0, NO_UPD}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cur_set = 0;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].set_id != cur_set) begin
                step_bus.valid <= 1'b0;
                cur_set = dir_rows[i].set_id;
                program_regs(dir_sets[cur_set]);
            end
            send_step(dir_rows[i].kind, dir_rows[i].sample, dir_rows[i].typed,
                      dir_rows[i].upd);
        end

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            step_bus.valid <= 1'b0;
            rs.a = pick_gain();
            rs.b = pick_gain();
            rs.h = pick_gain();
            rs.q = pick_noise();
            rs.r = pick_noise();
            program_regs(rs);
            send_burst = (ph == 1) || ($urandom_range(0, 3) == 0);
            recv_burst = (ph == 1) || ($urandom_range(0, 3) == 0);
            // stall the result side long enough to back up the input
            if (ph == 2)
                hold_request = 1'b1;
            n_items = $urandom_range(120, 165);
            repeat (n_items)
                send_step(($urandom_range(0, 1) == 0) ? skf_pkg::KIND_PREDICT
                                                      : skf_pkg::KIND_CORRECT,
                          pick_sample(), 1'b0, NO_UPD);
        end

        step_bus.valid <= 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d filter steps (%0d predict, %0d correct) under %0d register settings.",
                 predicts_sent + corrects_sent, predicts_sent, corrects_sent, settings_used);
        $display("Checked %0d result beats, %0d of them flagged as clipped.",
                 updates_seen, clipped_seen);
        if (mismatch_count == 0)
            $display("scalar_kalman_filter_top test passed");
        else
            $display("scalar_kalman_filter_top test failed");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("scalar_kalman_filter_top test failed");
        $finish;
    end

endmodule
